FILE: rtl/generations_automaton_stencil_core_assert.svh
// ----------------------------------------------------------------------------
// generations automaton stencil - assertion macros
// shared property forms for the stencil core and its sub-blocks
// ----------------------------------------------------------------------------
`ifndef GENERATIONS_AUTOMATON_STENCIL_CORE_ASSERT_SVH
`define GENERATIONS_AUTOMATON_STENCIL_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define GAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define GAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_pkg
// shared types and constants of the generations automaton stencil
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int AGE_W      = 8;
  localparam int CELL_W     = 10;
  localparam int ROW_W      = 16;
  localparam int ROW_IDX_W  = 17;   // counts up to row_count + 1
  localparam int CNT_W      = 4;    // neighbour count 0..8
  localparam int MASK_W     = 9;
  localparam int RLEN_W     = 11;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CELL_DEAD  = 2'd0,
    CELL_ALIVE = 2'd1,
    CELL_DYING = 2'd2
  } cell_state_t;

  typedef struct packed {
    cell_state_t      state;
    logic [AGE_W-1:0] age;
  } cell_t;

  // classification of one slot, made at accept time
  typedef struct packed {
    logic produce;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } item_flags_t;

  typedef struct packed {
    logic [MASK_W-1:0] birth_mask;
    logic [MASK_W-1:0] survive_mask;
    logic [AGE_W-1:0]  generations;
  } rule_cfg_t;

  typedef enum logic [2:0] {
    REG_BIRTH_MASK   = 3'd0,
    REG_SURVIVE_MASK = 3'd1,
    REG_GENERATIONS  = 3'd2,
    REG_ROW_LENGTH   = 3'd3,
    REG_ROW_COUNT    = 3'd4
  } reg_index_t;

  function automatic logic is_alive(cell_t c);
    return c.state == CELL_ALIVE;
  endfunction

endpackage

FILE: rtl/gas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_if
// valid/ready stream interfaces for cell items and result items
// ----------------------------------------------------------------------------
interface gas_cell_if;
  logic       valid;
  logic       ready;
  logic       fill;
  logic [1:0] cell_state;
  logic [7:0] cell_age;

  modport source (output valid, fill, cell_state, cell_age, input ready);
  modport sink   (input valid, fill, cell_state, cell_age, output ready);
endinterface

interface gas_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] next_state;
  logic [7:0] next_age;
  logic       frame_last;

  modport source (output valid, next_state, next_age, frame_last, input ready);
  modport sink   (input valid, next_state, next_age, frame_last, output ready);
endinterface

FILE: rtl/gas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gas_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/gas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_front
// accepts cell items, tracks the raster position and classifies each slot
// ----------------------------------------------------------------------------
`include "generations_automaton_stencil_core_assert.svh"

module gas_front import gas_pkg::*; #(
  parameter int MAX_COLS = 1024,
  localparam int COL_W   = $clog2(MAX_COLS),
  localparam int LEN_W   = $clog2(MAX_COLS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  gas_cell_if.sink          in_cell,
  input  logic [LEN_W-1:0]  eff_len,
  input  logic [ROW_W-1:0]  eff_rows,
  input  logic              restart,
  input  logic              q_full,
  output logic              q_push,
  output logic [COL_W-1:0]  q_col,
  output cell_t             q_cell,
  output item_flags_t       q_flags
);

  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic [ROW_IDX_W-1:0] rows_ext;
  logic [ROW_IDX_W-1:0] rows_plus1;
  logic [LEN_W-1:0]     col_inc;
  logic                 col_nz;
  logic                 accept;

  assign in_cell.ready = !q_full;
  assign accept        = in_cell.valid && in_cell.ready;
  assign q_push        = accept;

  assign rows_ext   = ROW_IDX_W'(eff_rows);
  assign rows_plus1 = rows_ext + ROW_IDX_W'(1);
  assign col_nz     = col_r != '0;
  assign col_inc    = LEN_W'(col_r) + LEN_W'(1);

  // incoming cell: padding and flush slots enter as dead, state 3 as dead
  always_comb begin
    q_cell.state = CELL_DEAD;
    q_cell.age   = '0;
    if (row_r < rows_ext && !in_cell.fill) begin
      q_cell.age = in_cell.cell_age;
      case (in_cell.cell_state)
        CELL_ALIVE: q_cell.state = CELL_ALIVE;
        CELL_DYING: q_cell.state = CELL_DYING;
        default:    q_cell.state = CELL_DEAD;
      endcase
    end
  end

  // window centre sits row_length+1 slots back
  always_comb begin
    q_col           = col_r;
    q_flags.produce = (row_r >= ROW_IDX_W'(2)) || (row_r == ROW_IDX_W'(1) && col_nz);
    q_flags.top     = col_nz ? (row_r == ROW_IDX_W'(1)) : (row_r == ROW_IDX_W'(2));
    q_flags.bottom  = col_nz ? (row_r == rows_ext) : (row_r == rows_plus1);
    q_flags.left    = (col_r == COL_W'(1)) || (!col_nz && eff_len == LEN_W'(1));
    q_flags.right   = !col_nz;
    q_flags.last    = (row_r == rows_plus1) && !col_nz;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (row_r >= rows_plus1) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= eff_len) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_IDX_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `GAS_ASSERT_IMPL(a_col_in_row, clk, rst_n, 1'b1, LEN_W'(col_r) < eff_len, "column past row")
  `GAS_ASSERT_IMPL(a_row_in_frame, clk, rst_n, 1'b1, row_r <= rows_plus1, "row past frame")

endmodule

FILE: rtl/gas_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_queue
// two-entry queue of classified slots between front and back
// ----------------------------------------------------------------------------
module gas_queue import gas_pkg::*; #(
  parameter int MAX_COLS = 1024,
  localparam int COL_W   = $clog2(MAX_COLS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [COL_W-1:0] push_col,
  input  cell_t            push_cell,
  input  item_flags_t      push_flags,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output logic [COL_W-1:0] pop_col,
  output cell_t            pop_cell,
  output item_flags_t      pop_flags
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [COL_W-1:0] col_mem   [DEPTH];
  cell_t            cell_mem  [DEPTH];
  item_flags_t      flags_mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_col   = col_mem[rd_ptr_r];
  assign pop_cell  = cell_mem[rd_ptr_r];
  assign pop_flags = flags_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      col_mem[wr_ptr_r]   <= push_col;
      cell_mem[wr_ptr_r]  <= push_cell;
      flags_mem[wr_ptr_r] <= push_flags;
    end
  end

endmodule

FILE: rtl/gas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_back
// row memories, 3x3 window, generations rule and result register
// ----------------------------------------------------------------------------
`include "generations_automaton_stencil_core_assert.svh"

module gas_back import gas_pkg::*; #(
  parameter int MAX_COLS = 1024,
  localparam int COL_W   = $clog2(MAX_COLS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rule_cfg_t        rule,
  input  logic             q_valid,
  output logic             q_pop,
  input  logic [COL_W-1:0] q_col,
  input  cell_t            q_cell,
  input  item_flags_t      q_flags,
  gas_result_if.source     out_result
);

  // read stage: slot whose row memories are being read
  logic             s2_valid_r, s2_valid_nxt;
  logic [COL_W-1:0] s2_col_r;
  cell_t            s2_cell_r;
  item_flags_t      s2_flags_r;
  logic             s2_fwd_r;
  cell_t            s2_fwd_mid_r;
  logic             s2_fwd_top_r;

  logic [CELL_W-1:0] mid_rd;
  logic [0:0]        top_rd;
  cell_t             mid_cur;
  logic              top_cur;

  // window history: two slots back of each of the three row streams
  logic  top_1_r, top_2_r;
  cell_t mid_1_r;
  logic  mid_2_r;
  logic  bot_1_r, bot_2_r;

  logic             out_valid_r, out_valid_nxt;
  cell_state_t      out_state_r;
  logic [AGE_W-1:0] out_age_r;
  logic             out_last_r;

  logic             out_free;
  logic             s2_fire;
  logic             collide;
  logic             en_t, en_b, en_l, en_r;
  logic [CNT_W-1:0] ncount;
  logic             survive, born;
  logic [AGE_W-1:0] age_inc;
  cell_state_t      res_state;
  logic [AGE_W-1:0] res_age;

  assign out_free = !out_valid_r || out_result.ready;
  assign s2_fire  = s2_valid_r && (!s2_flags_r.produce || out_free);
  assign q_pop    = q_valid && (!s2_valid_r || s2_fire);
  // same column read while it is written: only at a row length of one
  // or where a frame wraps to the next
  assign collide  = s2_fire && q_pop && (q_col == s2_col_r);

  assign mid_cur = s2_fwd_r ? s2_fwd_mid_r : cell_t'(mid_rd);
  assign top_cur = s2_fwd_r ? s2_fwd_top_r : top_rd[0];

  // row above the incoming one, full cells
  gas_ram #(.WIDTH(CELL_W), .DEPTH(MAX_COLS)) u_mid_ram (
    .clk     (clk),
    .wr_en   (s2_fire),
    .wr_addr (s2_col_r),
    .wr_data (s2_cell_r),
    .rd_en   (q_pop),
    .rd_addr (q_col),
    .rd_data (mid_rd)
  );

  // two rows above, alive bits only
  gas_ram #(.WIDTH(1), .DEPTH(MAX_COLS)) u_top_ram (
    .clk     (clk),
    .wr_en   (s2_fire),
    .wr_addr (s2_col_r),
    .wr_data (is_alive(mid_cur)),
    .rd_en   (q_pop),
    .rd_addr (q_col),
    .rd_data (top_rd)
  );

  // neighbour count with border masking
  always_comb begin
    en_t   = !s2_flags_r.top;
    en_b   = !s2_flags_r.bottom;
    en_l   = !s2_flags_r.left;
    en_r   = !s2_flags_r.right;
    ncount = CNT_W'(mid_2_r & en_l)
           + CNT_W'(is_alive(mid_cur) & en_r)
           + CNT_W'(top_1_r & en_t)
           + CNT_W'(top_2_r & en_t & en_l)
           + CNT_W'(top_cur & en_t & en_r)
           + CNT_W'(bot_1_r & en_b)
           + CNT_W'(bot_2_r & en_b & en_l)
           + CNT_W'(is_alive(s2_cell_r) & en_b & en_r);
  end

  assign survive = rule.survive_mask[ncount];
  assign born    = rule.birth_mask[ncount];
  assign age_inc = (mid_1_r.age == '1) ? mid_1_r.age : mid_1_r.age + AGE_W'(1);

  always_comb begin
    res_state = mid_1_r.state;
    res_age   = mid_1_r.age;
    if (!survive && (mid_1_r.state == CELL_ALIVE || mid_1_r.state == CELL_DYING)) begin
      res_age   = age_inc;
      res_state = (age_inc >= rule.generations) ? CELL_DEAD : CELL_DYING;
    end
    if (mid_1_r.state == CELL_DEAD && born) begin
      res_state = CELL_ALIVE;
      res_age   = '0;
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (q_pop) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_fire) begin
      s2_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_fire && s2_flags_r.produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_result.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_col_r     <= q_col;
      s2_cell_r    <= q_cell;
      s2_flags_r   <= q_flags;
      s2_fwd_r     <= collide;
      s2_fwd_mid_r <= s2_cell_r;
      s2_fwd_top_r <= is_alive(mid_cur);
    end
    if (s2_fire) begin
      top_2_r <= top_1_r;
      top_1_r <= top_cur;
      mid_2_r <= is_alive(mid_1_r);
      mid_1_r <= mid_cur;
      bot_2_r <= bot_1_r;
      bot_1_r <= is_alive(s2_cell_r);
      if (s2_flags_r.produce) begin
        out_state_r <= res_state;
        out_age_r   <= res_age;
        out_last_r  <= s2_flags_r.last;
      end
    end
  end

  assign out_result.valid      = out_valid_r;
  assign out_result.next_state = out_state_r;
  assign out_result.next_age   = out_age_r;
  assign out_result.frame_last = out_last_r;

  `GAS_ASSERT_IMPL(a_fwd_col_zero, clk, rst_n, s2_valid_r && s2_fwd_r, s2_col_r == '0, "forward off col 0")
  `GAS_ASSERT_NEXT(a_result_loaded, clk, rst_n, s2_fire && s2_flags_r.produce, out_valid_r, "result lost")
  `GAS_ASSERT_IMPL(a_last_corner, clk, rst_n, s2_valid_r && s2_flags_r.last, s2_flags_r.produce && s2_flags_r.bottom && s2_flags_r.right, "last not at corner")

endmodule

FILE: rtl/generations_automaton_stencil_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generations_automaton_stencil_core
// streaming 3x3 stencil for a generations-style cellular automaton
// ----------------------------------------------------------------------------
// usage:
// - in_cell takes one cell per slot in raster order (fill marks padding);
//   a frame is row_count*row_length grid slots then row_length+1 flush slots
// - out_result gives next_state/next_age of the cell row_length+1 slots
//   back, frame_last on the bottom-right cell; the first row_length+1 slots
//   of a frame give no result
// - throughput: one item per cycle while out_result is not stalled, set by
//   the single write port of each row memory being used once per slot
// - result path: the slot that completes a window passes through the queue
//   and the read stage, and its result is then loaded into the output register
// - a stalled out_result holds the result; in_cell keeps accepting until
//   the two-entry queue fills, and ready then drops
// - apb port: birth_mask, survive_mask, generations, row_length, row_count
//   at byte offsets 0..16; writing row_length or row_count restarts framing
// - reset clears config to defaults and the raster position; the row
//   memories are not cleared, since stale entries are always masked off
//   as border neighbours before they can reach a result
// ----------------------------------------------------------------------------
module generations_automaton_stencil_core import gas_pkg::*; #(
  parameter int MAX_COLS = 1024,
  localparam int COL_W   = $clog2(MAX_COLS),
  localparam int LEN_W   = $clog2(MAX_COLS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gas_cell_if.sink              in_cell,
  gas_result_if.source          out_result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [MASK_W-1:0] birth_mask_r, birth_mask_nxt;
  logic [MASK_W-1:0] survive_mask_r, survive_mask_nxt;
  logic [AGE_W-1:0]  generations_r, generations_nxt;
  logic [RLEN_W-1:0] row_length_r, row_length_nxt;
  logic [ROW_W-1:0]  row_count_r, row_count_nxt;

  reg_index_t        reg_idx;
  logic              cfg_wr;
  logic              restart;
  logic [LEN_W-1:0]  eff_len;
  logic [ROW_W-1:0]  eff_rows;
  rule_cfg_t         rule;

  // front to queue, queue to back
  logic              f_push;
  logic [COL_W-1:0]  f_col;
  cell_t             f_cell;
  item_flags_t       f_flags;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [COL_W-1:0]  q_col;
  cell_t             q_cell;
  item_flags_t       q_flags;

  // apb access: zero wait states, word-aligned registers
  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && (reg_idx == REG_ROW_LENGTH || reg_idx == REG_ROW_COUNT);

  always_comb begin
    birth_mask_nxt   = birth_mask_r;
    survive_mask_nxt = survive_mask_r;
    generations_nxt  = generations_r;
    row_length_nxt   = row_length_r;
    row_count_nxt    = row_count_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_BIRTH_MASK:   birth_mask_nxt   = pwdata[MASK_W-1:0];
        REG_SURVIVE_MASK: survive_mask_nxt = pwdata[MASK_W-1:0];
        REG_GENERATIONS:  generations_nxt  = pwdata[AGE_W-1:0];
        REG_ROW_LENGTH:   row_length_nxt   = pwdata[RLEN_W-1:0];
        REG_ROW_COUNT:    row_count_nxt    = pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_mask_r   <= MASK_W'(8);
      survive_mask_r <= MASK_W'(12);
      generations_r  <= AGE_W'(2);
      row_length_r   <= RLEN_W'(1024);
      row_count_r    <= ROW_W'(1024);
    end else begin
      birth_mask_r   <= birth_mask_nxt;
      survive_mask_r <= survive_mask_nxt;
      generations_r  <= generations_nxt;
      row_length_r   <= row_length_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BIRTH_MASK:   prdata = CFG_DATA_W'(birth_mask_r);
      REG_SURVIVE_MASK: prdata = CFG_DATA_W'(survive_mask_r);
      REG_GENERATIONS:  prdata = CFG_DATA_W'(generations_r);
      REG_ROW_LENGTH:   prdata = CFG_DATA_W'(row_length_r);
      REG_ROW_COUNT:    prdata = CFG_DATA_W'(row_count_r);
      default:          prdata = '0;
    endcase
  end

  // row length clamps to 1..MAX_COLS, row count of zero acts as one
  always_comb begin
    if (row_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(row_length_r) > 32'(MAX_COLS)) begin
      eff_len = LEN_W'(MAX_COLS);
    end else begin
      eff_len = LEN_W'(row_length_r);
    end
    eff_rows = (row_count_r == '0) ? ROW_W'(1) : row_count_r;
  end

  assign rule.birth_mask   = birth_mask_r;
  assign rule.survive_mask = survive_mask_r;
  assign rule.generations  = generations_r;

  // front: raster position and slot classification
  gas_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cell  (in_cell),
    .eff_len  (eff_len),
    .eff_rows (eff_rows),
    .restart  (restart),
    .q_full   (q_full),
    .q_push   (f_push),
    .q_col    (f_col),
    .q_cell   (f_cell),
    .q_flags  (f_flags)
  );

  // decoupling queue
  gas_queue #(.MAX_COLS(MAX_COLS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_col   (f_col),
    .push_cell  (f_cell),
    .push_flags (f_flags),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_col    (q_col),
    .pop_cell   (q_cell),
    .pop_flags  (q_flags)
  );

  // back: row memories, window, rule and result register
  gas_back #(.MAX_COLS(MAX_COLS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rule       (rule),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_col      (q_col),
    .q_cell     (q_cell),
    .q_flags    (q_flags),
    .out_result (out_result)
  );

endmodule
